// ----- sv/ckh_pkg.sv -----
// ----------------------------------------------------------------------------
// ckh_pkg: shared types and constants of the composite key hash
// Hash constants, component kind codes, multiplier operation codes, the
// controller state type and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ckh_pkg;

	// Mixing and hashing constants.
	localparam logic [63:0] GOLDEN    = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] SM_MUL1   = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] SM_MUL2   = 64'h94d0_49bb_1331_11eb;
	localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
	localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
	localparam logic [63:0] NA_MARK   = 64'hD1B5_4A32_D192_ED03;
	localparam logic [63:0] ROW_SEED  = 64'h726F_626F_746F_726F;

	// Per-kind tags.
	localparam logic [63:0] TAG_I = 64'h9ae1_6a3b_2f90_404f;
	localparam logic [63:0] TAG_R = 64'hc949_d7c7_509e_6557;
	localparam logic [63:0] TAG_S = 64'h8a5c_d789_635d_2dff;
	localparam logic [63:0] TAG_L = 64'h85eb_ca6b_27d4_eb4f;
	localparam logic [63:0] TAG_F = 64'h4cf5_ad43_2745_937f;
	localparam logic [63:0] TAG_D = 64'h94d0_49bb_1331_11eb;
	localparam logic [63:0] TAG_T = 64'hbf58_476d_1ce4_e5b9;

	// Double canonicalization masks.
	localparam logic [63:0] DBL_EXP_MASK  = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] DBL_MANT_MASK = 64'h000F_FFFF_FFFF_FFFF;
	localparam logic [63:0] DBL_NEG_ZERO  = 64'h8000_0000_0000_0000;

	// Logical codes.
	localparam logic [63:0] LGL_FALSE = 64'd0;
	localparam logic [63:0] LGL_TRUE  = 64'd1;
	localparam logic [63:0] LGL_NA    = 64'd2;

	// Component kinds.
	typedef enum logic [2:0] {
		KIND_INT      = 3'd0,
		KIND_LGL      = 3'd1,
		KIND_DBL      = 3'd2,
		KIND_DATE     = 3'd3,
		KIND_DATETIME = 3'd4,
		KIND_STR      = 3'd5,
		KIND_FACTOR   = 3'd6
	} kind_t;

	// Operations of the shared multiplier.
	typedef enum logic [2:0] {
		MOP_FNV = 3'd0,
		MOP_SM1 = 3'd1,
		MOP_SM2 = 3'd2,
		MOP_TAG = 3'd3,
		MOP_ACC = 3'd4
	} mop_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_FNV,
		S_FNV_W,
		S_LOAD,
		S_SM1,
		S_SM1_W,
		S_SM2,
		S_SM2_W,
		S_SMX,
		S_TAG,
		S_TAG_W,
		S_ACC,
		S_ACC_W,
		S_ROW,
		S_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic load;
		logic mul_start;
		mop_t mop;
		logic smx;
		logic row_load;
		logic emit;
	} ckh_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fnv;
		logic have;
		logic need_sm;
		logic row_end;
		logic mul_done;
		logic out_full;
	} ckh_sts_t;

endpackage

// ----- sv/ckh_mul64.sv -----
// ----------------------------------------------------------------------------
// ckh_mul64: serial 64 by 64 multiplier, low 64 bits of the product
// One 32x32 multiplier is used in turn: low by low, then the two
// cross products, whose low halves are added into the upper word.
// ----------------------------------------------------------------------------
module ckh_mul64 import ckh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);

	localparam logic [1:0] STEP_LO   = 2'd0;
	localparam logic [1:0] STEP_LAST = 2'd2;

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] p_q;
	logic [1:0]  step_q;
	logic        run_q;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] prod;
	logic [63:0] p_sum;

	// Select the partial product for this step.
	always_comb begin
		case (step_q)
			STEP_LO: begin
				ma = a_q[31:0];
				mb = b_q[31:0];
			end
			2'd1: begin
				ma = a_q[31:0];
				mb = b_q[63:32];
			end
			default: begin
				ma = a_q[63:32];
				mb = b_q[31:0];
			end
		endcase
	end

	assign prod  = {32'd0, ma} * {32'd0, mb};
	assign p_sum = (step_q == STEP_LO) ? prod
		: {p_q[63:32] + prod[31:0], p_q[31:0]};

	assign done = run_q && (step_q == STEP_LAST);
	assign p    = p_sum;

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= STEP_LO;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= STEP_LO;
		end else if (run_q) begin
			if (step_q == STEP_LAST) begin
				run_q <= 1'b0;
			end else begin
				step_q <= step_q + 2'd1;
			end
		end
	end

	// Operand and partial sum registers.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (run_q) begin
			p_q <= p_sum;
		end
	end

endmodule

// ----- sv/ckh_datapath.sv -----
// ----------------------------------------------------------------------------
// ckh_datapath: registers and operand logic of the composite key hash
// Holds the captured transaction, the working word, the row and string
// accumulators and the output register, and feeds the shared multiplier.
// ----------------------------------------------------------------------------
module ckh_datapath import ckh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ckh_cmd_t    cmd,
	output ckh_sts_t    sts,
	input  logic [2:0]  kind,
	input  logic        missing,
	input  logic [63:0] value,
	input  logic        byte_present,
	input  logic        value_end,
	input  logic        row_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_out
);

	kind_t       kind_q;
	logic        missing_q;
	logic [63:0] value_q;
	logic        bp_q;
	logic        ve_q;
	logic        re_q;
	logic [63:0] w_q;
	logic [63:0] acc_q;
	logic [63:0] str_q;
	logic [31:0] hash_q;
	logic        out_valid_q;
	mop_t        dest_q;

	logic        str_kind;
	logic        dbl_kind;
	logic        have;
	logic        plain_na;
	logic [63:0] canon;
	logic [63:0] src;
	logic [63:0] tag;
	logic [63:0] w_rot;
	logic [63:0] sm_add;
	logic [63:0] mul_a;
	logic [63:0] mul_b;
	logic        mul_done;
	logic [63:0] mul_p;

	// Decode of the captured transaction.
	assign str_kind = (kind_q == KIND_STR) || (kind_q == KIND_FACTOR);
	assign dbl_kind = (kind_q == KIND_DBL) || (kind_q == KIND_DATE)
		|| (kind_q == KIND_DATETIME);
	assign have = (kind_q == KIND_INT) || (kind_q == KIND_LGL) || dbl_kind
		|| (str_kind && (missing_q || ve_q || re_q));
	assign plain_na = missing_q && ((kind_q == KIND_INT) || str_kind);

	// Canonical double: missing and NaN map to the marker, -0.0 to +0.0.
	always_comb begin
		if (missing_q || (((value_q & DBL_EXP_MASK) == DBL_EXP_MASK)
			&& ((value_q & DBL_MANT_MASK) != 64'd0))) begin
			canon = NA_MARK;
		end else if (value_q == DBL_NEG_ZERO) begin
			canon = 64'd0;
		end else begin
			canon = value_q;
		end
	end

	// Component source word and tag by kind.
	always_comb begin
		case (kind_q)
			KIND_INT: begin
				src = missing_q ? NA_MARK : {32'd0, value_q[31:0]};
				tag = TAG_I;
			end
			KIND_LGL: begin
				src = missing_q ? LGL_NA : ((value_q != 64'd0) ? LGL_TRUE : LGL_FALSE);
				tag = TAG_L;
			end
			KIND_DBL: begin
				src = canon;
				tag = TAG_R;
			end
			KIND_DATE: begin
				src = canon;
				tag = TAG_D;
			end
			KIND_DATETIME: begin
				src = canon;
				tag = TAG_T;
			end
			KIND_STR: begin
				src = missing_q ? NA_MARK : str_q;
				tag = TAG_S;
			end
			KIND_FACTOR: begin
				src = missing_q ? NA_MARK : str_q;
				tag = TAG_F;
			end
			default: begin
				src = 64'd0;
				tag = TAG_I;
			end
		endcase
	end

	// Multiplier operands.
	assign w_rot  = {w_q[40:0], w_q[63:41]};
	assign sm_add = w_q + GOLDEN;

	always_comb begin
		case (cmd.mop)
			MOP_FNV: begin
				mul_a = str_q ^ {56'd0, value_q[7:0]};
				mul_b = FNV_PRIME;
			end
			MOP_SM1: begin
				mul_a = sm_add ^ (sm_add >> 30);
				mul_b = SM_MUL1;
			end
			MOP_SM2: begin
				mul_a = w_q ^ (w_q >> 27);
				mul_b = SM_MUL2;
			end
			MOP_TAG: begin
				mul_a = tag ^ w_rot;
				mul_b = GOLDEN;
			end
			MOP_ACC: begin
				mul_a = acc_q ^ w_rot;
				mul_b = GOLDEN;
			end
			default: begin
				mul_a = w_q;
				mul_b = GOLDEN;
			end
		endcase
	end

	ckh_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// Status toward the controller.
	assign sts.fnv      = str_kind && !missing_q && bp_q;
	assign sts.have     = have;
	assign sts.need_sm  = have && !plain_na;
	assign sts.row_end  = re_q;
	assign sts.mul_done = mul_done;
	assign sts.out_full = out_valid_q && !out_ready;

	// Captured transaction fields.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q    <= kind_t'(kind);
			missing_q <= missing;
			value_q   <= value;
			bp_q      <= byte_present;
			ve_q      <= value_end;
			re_q      <= row_end;
		end
		if (cmd.mul_start) begin
			dest_q <= cmd.mop;
		end
	end

	// Working word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q <= src;
		end else if (cmd.row_load) begin
			w_q <= acc_q;
		end else if (cmd.smx) begin
			w_q <= w_q ^ (w_q >> 31);
		end else if (mul_done && (dest_q != MOP_FNV) && (dest_q != MOP_ACC)) begin
			w_q <= mul_p;
		end
	end

	// Row and string accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= ROW_SEED;
			str_q <= FNV_BASIS;
		end else begin
			if (cmd.row_load) begin
				acc_q <= ROW_SEED;
				str_q <= FNV_BASIS;
			end else if (cmd.load && str_kind && have) begin
				str_q <= FNV_BASIS;
			end else if (mul_done && (dest_q == MOP_FNV)) begin
				str_q <= mul_p;
			end else if (mul_done && (dest_q == MOP_ACC)) begin
				acc_q <= mul_p;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hash_q <= w_q[63:32] ^ w_q[31:0];
		end
	end

	assign out_valid = out_valid_q;
	assign hash_out  = hash_q;

endmodule

// ----- sv/ckh_ctrl.sv -----
// ----------------------------------------------------------------------------
// ckh_ctrl: sequencing controller of the composite key hash
// Steps each transaction through the FNV update, splitmix rounds, tag fold
// and row fold, and the row finalizer, issuing one multiply at a time.
// ----------------------------------------------------------------------------
module ckh_ctrl import ckh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output ckh_cmd_t cmd,
	input  ckh_sts_t sts
);

	state_t state_q;
	state_t state_d;
	logic   row_phase_q;
	logic   row_phase_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_phase_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			row_phase_q <= row_phase_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		row_phase_d   = row_phase_q;
		in_ready      = 1'b0;
		cmd.capture   = 1'b0;
		cmd.load      = 1'b0;
		cmd.mul_start = 1'b0;
		cmd.mop       = MOP_SM1;
		cmd.smx       = 1'b0;
		cmd.row_load  = 1'b0;
		cmd.emit      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = sts.fnv ? S_FNV : S_LOAD;
			end
			S_FNV: begin
				cmd.mul_start = 1'b1;
				cmd.mop       = MOP_FNV;
				state_d       = S_FNV_W;
			end
			S_FNV_W: begin
				cmd.mop = MOP_FNV;
				if (sts.mul_done) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				if (!sts.have) begin
					state_d = sts.row_end ? S_ROW : S_IDLE;
				end else begin
					state_d = sts.need_sm ? S_SM1 : S_TAG;
				end
			end
			S_SM1: begin
				cmd.mul_start = 1'b1;
				cmd.mop       = MOP_SM1;
				state_d       = S_SM1_W;
			end
			S_SM1_W: begin
				cmd.mop = MOP_SM1;
				if (sts.mul_done) begin
					state_d = S_SM2;
				end
			end
			S_SM2: begin
				cmd.mul_start = 1'b1;
				cmd.mop       = MOP_SM2;
				state_d       = S_SM2_W;
			end
			S_SM2_W: begin
				cmd.mop = MOP_SM2;
				if (sts.mul_done) begin
					state_d = S_SMX;
				end
			end
			S_SMX: begin
				cmd.smx = 1'b1;
				state_d = row_phase_q ? S_EMIT : S_TAG;
			end
			S_TAG: begin
				cmd.mul_start = 1'b1;
				cmd.mop       = MOP_TAG;
				state_d       = S_TAG_W;
			end
			S_TAG_W: begin
				cmd.mop = MOP_TAG;
				if (sts.mul_done) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.mul_start = 1'b1;
				cmd.mop       = MOP_ACC;
				state_d       = S_ACC_W;
			end
			S_ACC_W: begin
				cmd.mop = MOP_ACC;
				if (sts.mul_done) begin
					state_d = sts.row_end ? S_ROW : S_IDLE;
				end
			end
			S_ROW: begin
				cmd.row_load = 1'b1;
				row_phase_d  = 1'b1;
				state_d      = S_SM1;
			end
			S_EMIT: begin
				if (!sts.out_full) begin
					cmd.emit    = 1'b1;
					row_phase_d = 1'b0;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	// A result is written only when the output register has room.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_full)
		else $error("row hash written over a result not yet taken");

	// Multiplier completions arrive only while a multiply is awaited.
	a_mul_expected: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> (state_q == S_FNV_W || state_q == S_SM1_W
			|| state_q == S_SM2_W || state_q == S_TAG_W || state_q == S_ACC_W))
		else $error("multiplier completion outside a wait state");

	// No new transaction is taken while a row finalization is open.
	a_idle_no_row: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !row_phase_q)
		else $error("input ready during row finalization");

	// After a result is written the block is ready for the next row.
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> in_ready)
		else $error("controller not idle after emitting a row hash");
`endif

endmodule

// ----- sv/composite_key_hash.sv -----
// Each 64-bit product runs on the single shared 32x32 multiplier, and up to seven
// products are chained per transaction; a new transaction is taken only when the
// last one is through. The output register lets the next row run ahead.
// Reset: arst_n clears control and loads the row seed and the FNV offset basis.
// ----------------------------------------------------------------------------
// composite_key_hash: composite key row hash, top level
// Folds integer, logical, double, date, datetime, string and factor
// components of a row into a seeded accumulator and emits a 32-bit hash.
// ----------------------------------------------------------------------------
module composite_key_hash import ckh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic        missing,
	input  logic [63:0] value,
	input  logic        byte_present,
	input  logic        value_end,
	input  logic        row_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_out
);

	ckh_cmd_t cmd;
	ckh_sts_t sts;

	// Sequencing controller.
	ckh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Hash datapath.
	ckh_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.missing      (missing),
		.value        (value),
		.byte_present (byte_present),
		.value_end    (value_end),
		.row_end      (row_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hash_out     (hash_out)
	);

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the composite key hash
// Sends rows of integer, logical, double, date, datetime, string and factor
// components through the input handshake and predicts each row hash with an
// independent model of the accumulator and string state. Every hash taken
// from the output handshake is compared with the oldest prediction.
// ----------------------------------------------------------------------------

import ckh_pkg::*;

// Predicts row hashes and checks the hashes that the block gives.
class key_hash_board;
	logic [63:0] row_acc;
	logic [63:0] str_acc;
	logic [31:0] expected_hashes[$];
	int          mismatches;
	int          hashes_checked;

	function new();
		row_acc = ROW_SEED;
		str_acc = FNV_BASIS;
		mismatches = 0;
		hashes_checked = 0;
	endfunction

	function logic [63:0] splitmix(logic [63:0] x);
		logic [63:0] z;
		z = x + GOLDEN;
		z = (z ^ (z >> 30)) * SM_MUL1;
		z = (z ^ (z >> 27)) * SM_MUL2;
		return z ^ (z >> 31);
	endfunction

	// XOR in the hash rotated left by 23, then multiply by the golden ratio.
	function logic [63:0] fold_in(logic [63:0] acc, logic [63:0] h);
		logic [63:0] t;
		t = acc ^ {h[40:0], h[63:41]};
		return t * GOLDEN;
	endfunction

	// NA and any NaN map to the sentinel; negative zero maps to positive zero.
	function logic [63:0] canonical(logic [63:0] bits, logic miss);
		if (miss)
			return NA_MARK;
		if ((bits & DBL_EXP_MASK) == DBL_EXP_MASK && (bits & DBL_MANT_MASK) != 0)
			return NA_MARK;
		if (bits == DBL_NEG_ZERO)
			return 64'd0;
		return bits;
	endfunction

	// Takes one accepted transaction and queues the row hash it completes.
	function void absorb(logic [2:0] k, logic miss, logic [63:0] v, logic bp, logic ve,
			logic re);
		logic [63:0] h;
		logic [63:0] tag;
		logic [63:0] f;
		logic        folded;
		h = '0;
		folded = 1'b0;
		case (k)
			KIND_INT: begin
				h = miss ? fold_in(TAG_I, NA_MARK)
					: fold_in(TAG_I, splitmix({32'd0, v[31:0]}));
				folded = 1'b1;
			end
			KIND_LGL: begin
				h = fold_in(TAG_L, splitmix(miss ? LGL_NA : (v != 0 ? LGL_TRUE : LGL_FALSE)));
				folded = 1'b1;
			end
			KIND_DBL, KIND_DATE, KIND_DATETIME: begin
				tag = (k == KIND_DBL) ? TAG_R : ((k == KIND_DATE) ? TAG_D : TAG_T);
				h = fold_in(tag, splitmix(canonical(v, miss)));
				folded = 1'b1;
			end
			KIND_STR, KIND_FACTOR: begin
				tag = (k == KIND_STR) ? TAG_S : TAG_F;
				if (miss) begin
					h = fold_in(tag, NA_MARK);
					str_acc = FNV_BASIS;
					folded = 1'b1;
				end else begin
					if (bp)
						str_acc = (str_acc ^ {56'd0, v[7:0]}) * FNV_PRIME;
					if (ve || re) begin
						h = fold_in(tag, splitmix(str_acc));
						str_acc = FNV_BASIS;
						folded = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (folded)
			row_acc = fold_in(row_acc, h);
		if (re) begin
			f = splitmix(row_acc);
			expected_hashes.push_back(f[63:32] ^ f[31:0]);
			row_acc = ROW_SEED;
			str_acc = FNV_BASIS;
		end
	endfunction

	task report_mismatch(string what);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	task check_hash(logic [31:0] got);
		logic [31:0] want;
		hashes_checked++;
		if (expected_hashes.size() == 0) begin
			report_mismatch($sformatf("row hash %h with no row pending", got));
		end else begin
			want = expected_hashes.pop_front();
			if (got !== want)
				report_mismatch($sformatf("hash_out %h, predicted %h", got, want));
		end
	endtask
endclass

module tb;

	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam int         RAND_ITEMS = 500;
	localparam int         DRAIN_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  kind;
	logic        missing;
	logic [63:0] value;
	logic        byte_present;
	logic        value_end;
	logic        row_end;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] hash_out;

	key_hash_board hashes = new();

	// Stretch in which neither side idles.
	bit calm = 1'b0;

	int items_sent = 0;
	int rows_sent = 0;
	int bytes_sent = 0;
	int missing_sent = 0;

	composite_key_hash DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.missing(missing),
		.value(value),
		.byte_present(byte_present),
		.value_end(value_end),
		.row_end(row_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hash_out(hash_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Offers one transaction, maybe after an idle gap, and waits for acceptance.
	task automatic send_item(logic [2:0] k, logic miss, logic [63:0] v, logic bp,
			logic ve, logic re);
		if (!calm && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		missing <= miss;
		value <= v;
		byte_present <= bp;
		value_end <= ve;
		row_end <= re;
		do
			@(posedge clk);
		while (!in_ready);
		hashes.absorb(k, miss, v, bp, ve, re);
		items_sent++;
		if (re)
			rows_sent++;
		if (miss)
			missing_sent++;
		if ((k == KIND_STR || k == KIND_FACTOR) && bp && !miss)
			bytes_sent++;
	endtask

	// Zeros, infinities, NaNs with a random payload, and random bit patterns.
	function automatic logic [63:0] rand_double();
		logic [63:0] r;
		r = rand64();
		case ($urandom_range(7))
			0: return 64'd0;
			1: return DBL_NEG_ZERO;
			2: return {r[63], 11'h7FF, 52'd0};
			3: return {r[63], 11'h7FF, r[50:0], 1'b1};
			default: return r;
		endcase
	endfunction

	// One string or factor component, mostly well formed, sometimes broken.
	task automatic send_text(logic [2:0] k, bit last);
		int  n;
		bit  cut;
		if ($urandom_range(9) == 0) begin
			send_item(k, 1'b1, rand64(), 1'($urandom_range(1)), 1'($urandom_range(1)),
				last);
		end else begin
			n = ($urandom_range(19) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 5);
			// Row end may close the string without a value end.
			cut = last && ($urandom_range(7) == 0);
			if (n == 0)
				send_item(k, 1'b0, rand64(), 1'b0, !cut, last);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(19) == 0)
					send_item(k, 1'b0, rand64(), 1'b0, 1'b0, 1'b0);
				send_item(k, 1'b0, rand64(), 1'b1, (i == n - 1) && !cut,
					(i == n - 1) && last);
			end
		end
	endtask

	// One scalar component, or now and then an item of the unused kind.
	task automatic send_scalar(logic [2:0] k, bit last);
		logic [63:0] v;
		logic        miss;
		miss = ($urandom_range(9) == 0);
		case (k)
			KIND_LGL:
				v = ($urandom_range(2) == 0) ? 64'd0 : rand64();
			KIND_DBL, KIND_DATE, KIND_DATETIME:
				v = rand_double();
			default:
				v = rand64();
		endcase
		send_item(k, miss, v, 1'($urandom_range(1)), 1'($urandom_range(1)), last);
	endtask

	task automatic send_row();
		int          ncomp;
		logic [2:0]  k;
		ncomp = $urandom_range(1, 5);
		for (int c = 0; c < ncomp; c++) begin
			k = ($urandom_range(99) < 4) ? KIND_UNUSED : 3'($urandom_range(0, 6));
			if (k == KIND_STR || k == KIND_FACTOR)
				send_text(k, c == ncomp - 1);
			else
				send_scalar(k, c == ncomp - 1);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (hashes.expected_hashes.size() != 0);
	endtask

	// Result side: random stalls, plus one long hold-off that fills the block.
	initial begin
		int hold_left;
		bit held_once;
		hold_left = 0;
		held_once = 1'b0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				hashes.check_hash(hash_out);
			if (!held_once && hashes.hashes_checked == 30) begin
				held_once = 1'b1;
				hold_left = 500;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 11);
			end
		end
	end

	// Stimulus: reset, directed rows, random rows, then drain and report.
	initial begin
		int rand_rows;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_INT;
		missing <= 1'b0;
		value <= '0;
		byte_present <= 1'b0;
		value_end <= 1'b0;
		row_end <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Integer extremes; string flags on a scalar kind are ignored.
		send_item(KIND_INT, 1'b0, '1, 1'b1, 1'b1, 1'b0);
		send_item(KIND_INT, 1'b0, '0, 1'b0, 1'b0, 1'b1);
		// Missing integer and all logical codes.
		send_item(KIND_INT, 1'b1, rand64(), 1'b0, 1'b0, 1'b0);
		send_item(KIND_LGL, 1'b0, '0, 1'b0, 1'b0, 1'b0);
		send_item(KIND_LGL, 1'b0, DBL_NEG_ZERO, 1'b0, 1'b0, 1'b0);
		send_item(KIND_LGL, 1'b1, '1, 1'b0, 1'b0, 1'b1);
		// Signed zeros, NaN and missing doubles over the three double tags.
		send_item(KIND_DBL, 1'b0, DBL_NEG_ZERO, 1'b0, 1'b0, 1'b0);
		send_item(KIND_DBL, 1'b0, 64'd0, 1'b0, 1'b0, 1'b0);
		send_item(KIND_DATE, 1'b0, 64'h7FF8_0000_0000_0001, 1'b0, 1'b0, 1'b0);
		send_item(KIND_DATETIME, 1'b1, 64'd0, 1'b0, 1'b0, 1'b1);
		// Infinity, an all-ones NaN, an empty string, and row end on the unused kind.
		send_item(KIND_DBL, 1'b0, DBL_EXP_MASK, 1'b0, 1'b0, 1'b0);
		send_item(KIND_DATE, 1'b0, '1, 1'b0, 1'b0, 1'b0);
		send_item(KIND_STR, 1'b0, rand64(), 1'b0, 1'b1, 1'b0);
		send_item(KIND_UNUSED, 1'b0, rand64(), 1'b1, 1'b1, 1'b1);
		// A short string, a missing factor, and a string closed by row end.
		send_item(KIND_STR, 1'b0, 64'h61, 1'b1, 1'b0, 1'b0);
		send_item(KIND_STR, 1'b0, 64'h62, 1'b1, 1'b1, 1'b0);
		send_item(KIND_FACTOR, 1'b1, 64'hFF, 1'b1, 1'b0, 1'b0);
		send_item(KIND_STR, 1'b0, 64'h78, 1'b1, 1'b0, 1'b0);
		send_item(KIND_STR, 1'b0, 64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b0, 1'b1);
		// Factor bytes at both extremes; a missing string that cuts a string short.
		send_item(KIND_FACTOR, 1'b0, 64'hFF, 1'b1, 1'b0, 1'b0);
		send_item(KIND_FACTOR, 1'b0, 64'h00, 1'b1, 1'b1, 1'b0);
		send_item(KIND_STR, 1'b0, 64'h7A, 1'b1, 1'b0, 1'b0);
		send_item(KIND_STR, 1'b1, 64'h7A, 1'b1, 1'b1, 1'b0);
		send_item(KIND_DATETIME, 1'b0, DBL_NEG_ZERO, 1'b0, 1'b0, 1'b1);
		// A row with no component at all.
		send_item(KIND_UNUSED, 1'b1, '0, 1'b0, 1'b0, 1'b1);
		wait_drained();

		rand_rows = 0;
		while (items_sent < 25 + RAND_ITEMS) begin
			calm = (rand_rows >= 45 && rand_rows < 60);
			if (rand_rows == 20)
				wait_drained();
			send_row();
			rand_rows++;
		end
		calm = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d transactions in %0d rows: %0d string bytes, %0d missing values.",
			items_sent, rows_sent, bytes_sent, missing_sent);
		$display("Checked %0d row hashes, %0d mismatches.", hashes.hashes_checked,
			hashes.mismatches);
		if (hashes.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("Timeout with %0d row hashes outstanding.", hashes.expected_hashes.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- composite_key_hash.f -----
sv/ckh_pkg.sv
sv/ckh_mul64.sv
sv/ckh_datapath.sv
sv/ckh_ctrl.sv
sv/composite_key_hash.sv
dv/tb.sv
